[hw/rtl/tpdq_pkg.sv]
// shared types and constants for the tree path distance query block
package tpdq_pkg;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned NODE_W = 10;
	localparam int unsigned WT_W   = 16;
	localparam int unsigned DIST_W = 26;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [WT_W-1:0]   weight_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		node_t   a;
		node_t   b;
		weight_t w;
	} edge_t;

endpackage

[hw/rtl/tpdq_ram.sv]
// generic single write port, single read port ram with registered read
module tpdq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/tree_path_distance_query.sv]
// tree path distance query: edge store, depth-first walk sequencer and result register
//
// Edges are loaded one beat a cycle into an edge store while no query runs; a
// clear beat empties it. A query beat (start, target) runs a depth-first walk
// over the stored edges in load order and returns one result beat: the path
// weight with found set, or zero with found clear. A query first clears every
// entry of the visited map, then sets up the root. Each edge examined then
// passes through an edge read and an end check, plus a visited read and a
// decision when it touches the top node. Each pop runs through end of list, pop
// and frame reload. Every node on the walk rescans the edge list from its start,
// all through the single edge store read port. A query with start equal to
// target, or a node out of range, skips the walk and goes straight to the
// result state. Input is stalled while a query runs and while its result waits
// for the output register; a waiting result beat does not block edge loads.
module tree_path_distance_query #(
	parameter int unsigned MAX_NODES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tpdq_pkg::OP_W-1:0]    operation,
	input  logic [tpdq_pkg::NODE_W-1:0]  node_a,
	input  logic [tpdq_pkg::NODE_W-1:0]  node_b,
	input  logic [tpdq_pkg::WT_W-1:0]    weight,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tpdq_pkg::DIST_W-1:0]  distance,
	output logic                         found
);

	localparam int unsigned AW  = $clog2(MAX_NODES);
	localparam int unsigned SW  = $clog2(MAX_NODES + 1);
	localparam int unsigned STW = tpdq_pkg::NODE_W + AW + tpdq_pkg::WT_W;
	localparam int unsigned EW  = $bits(tpdq_pkg::edge_t);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_INIT = 4'd2;
	localparam logic [3:0] ST_RDE  = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_VIS  = 4'd5;
	localparam logic [3:0] ST_POP  = 4'd6;
	localparam logic [3:0] ST_LOAD = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]            state_q;
	logic [AW-1:0]         ecount_q;
	logic [AW-1:0]         clr_q;
	logic [SW-1:0]         sp_q;
	logic [SW-1:0]         sp_m1;
	logic [SW-1:0]         sp_m2;
	tpdq_pkg::node_t       start_q;
	tpdq_pkg::node_t       target_q;
	tpdq_pkg::node_t       top_node_q;
	logic [AW-1:0]         cursor_q;
	tpdq_pkg::weight_t     top_w_q;
	tpdq_pkg::node_t       other_q;
	tpdq_pkg::weight_t     ew_q;
	tpdq_pkg::dist_t       dist_q;
	tpdq_pkg::dist_t       res_dist_q;
	logic                  res_found_q;
	logic                  out_valid_q;
	tpdq_pkg::dist_t       distance_q;
	logic                  found_q;

	logic                  accept;
	logic                  add_ok;
	logic                  e_we;
	tpdq_pkg::edge_t       e_wdata;
	logic [EW-1:0]         e_rdata;
	tpdq_pkg::edge_t       e_rd;
	logic                  v_we;
	logic [AW-1:0]         v_waddr;
	logic                  v_wdata;
	logic [AW-1:0]         v_raddr;
	logic                  v_rdata;
	logic                  s_we;
	logic [STW-1:0]        s_wdata;
	logic [STW-1:0]        s_rdata;
	logic                  e_match;
	tpdq_pkg::node_t       e_other;
	tpdq_pkg::dist_t       dist_add;
	logic                  out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign sp_m1    = sp_q - SW'(1);
	assign sp_m2    = sp_q - SW'(2);
	assign e_rd     = tpdq_pkg::edge_t'(e_rdata);
	assign dist_add = dist_q + tpdq_pkg::dist_t'(ew_q);

	assign add_ok = (32'(ecount_q) < 32'(MAX_NODES - 1)) &&
	                (32'(node_a) < 32'(MAX_NODES)) && (32'(node_b) < 32'(MAX_NODES));

	// edge store
	assign e_we    = accept && (operation == tpdq_pkg::OP_ADD) && add_ok;
	assign e_wdata = '{a: node_a, b: node_b, w: weight};

	tpdq_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (ecount_q),
		.wdata (e_wdata),
		.raddr (cursor_q),
		.rdata (e_rdata)
	);

	// which end of the fetched edge leads away from the top node
	always_comb begin
		e_match = 1'b1;
		e_other = e_rd.b;
		if (e_rd.a == top_node_q) begin
			e_other = e_rd.b;
		end else if (e_rd.b == top_node_q) begin
			e_other = e_rd.a;
		end else begin
			e_match = 1'b0;
		end
	end

	// visited map
	always_comb begin
		v_we    = 1'b0;
		v_waddr = clr_q;
		v_wdata = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				v_we = 1'b1;
			end
			ST_INIT: begin
				v_we    = 1'b1;
				v_waddr = AW'(start_q);
				v_wdata = 1'b1;
			end
			ST_VIS: begin
				v_we    = !v_rdata && (other_q != target_q) && (32'(sp_q) < 32'(MAX_NODES));
				v_waddr = AW'(other_q);
				v_wdata = 1'b1;
			end
			default: begin
				v_we = 1'b0;
			end
		endcase
	end

	assign v_raddr = AW'(e_other);

	tpdq_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// walk stack holds every frame below the top one
	assign s_we    = (state_q == ST_VIS) && v_we;
	assign s_wdata = {top_node_q, cursor_q + AW'(1), top_w_q};

	tpdq_ram #(.WIDTH(STW), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (sp_m1[AW-1:0]),
		.wdata (s_wdata),
		.raddr (sp_m2[AW-1:0]),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ecount_q    <= '0;
			clr_q       <= '0;
			sp_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q  <= node_a;
						target_q <= node_b;
						if (operation == tpdq_pkg::OP_CLEAR) begin
							ecount_q <= '0;
						end else if (e_we) begin
							ecount_q <= ecount_q + AW'(1);
						end else if (operation == tpdq_pkg::OP_QUERY) begin
							res_dist_q <= '0;
							if (node_a == node_b) begin
								res_found_q <= 1'b1;
								state_q     <= ST_OUT;
							end else if ((32'(node_a) >= 32'(MAX_NODES)) ||
							             (32'(node_b) >= 32'(MAX_NODES))) begin
								res_found_q <= 1'b0;
								state_q     <= ST_OUT;
							end else begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_NODES - 1)) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					top_node_q <= start_q;
					cursor_q   <= '0;
					top_w_q    <= '0;
					dist_q     <= '0;
					sp_q       <= SW'(1);
					state_q    <= ST_RDE;
				end
				ST_RDE: begin
					if (cursor_q >= ecount_q) begin
						state_q <= ST_POP;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					other_q <= e_other;
					ew_q    <= e_rd.w;
					if (e_match) begin
						state_q <= ST_VIS;
					end else begin
						cursor_q <= cursor_q + AW'(1);
						state_q  <= ST_RDE;
					end
				end
				ST_VIS: begin
					if (v_rdata) begin
						cursor_q <= cursor_q + AW'(1);
						state_q  <= ST_RDE;
					end else if (other_q == target_q) begin
						res_dist_q  <= dist_add;
						res_found_q <= 1'b1;
						state_q     <= ST_OUT;
					end else if (32'(sp_q) >= 32'(MAX_NODES)) begin
						res_found_q <= 1'b0;
						state_q     <= ST_OUT;
					end else begin
						dist_q     <= dist_add;
						top_node_q <= other_q;
						cursor_q   <= '0;
						top_w_q    <= ew_q;
						sp_q       <= sp_q + SW'(1);
						state_q    <= ST_RDE;
					end
				end
				ST_POP: begin
					dist_q <= dist_q - tpdq_pkg::dist_t'(top_w_q);
					sp_q   <= sp_m1;
					if (sp_q == SW'(1)) begin
						res_found_q <= 1'b0;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					{top_node_q, cursor_q, top_w_q} <= s_rdata;
					state_q <= ST_RDE;
				end
				ST_OUT: begin
					if (out_free) begin
						distance_q  <= res_dist_q;
						found_q     <= res_found_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign found     = found_q;

endmodule

[test/tb_tree_path_distance_query.sv]
// testbench for the tree path distance query block: directed cases, random trees, queries and idling
module tb_tree_path_distance_query;

	localparam int unsigned NODES     = 1024;
	localparam int unsigned WATCH_MAX = 60000;
	localparam logic [tpdq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [tpdq_pkg::OP_W-1:0] op;
		tpdq_pkg::node_t           a;
		tpdq_pkg::node_t           b;
		tpdq_pkg::weight_t         w;
	} beat_t;

	typedef struct {
		tpdq_pkg::dist_t path_sum;
		logic            hit;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [tpdq_pkg::OP_W-1:0] operation = '0;
	tpdq_pkg::node_t node_a = '0;
	tpdq_pkg::node_t node_b = '0;
	tpdq_pkg::weight_t weight = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tpdq_pkg::dist_t distance;
	logic found;

	beat_t   pending_beats[$];
	answer_t expected_answers[$];

	// model copy of the edge store and walk state
	tpdq_pkg::edge_t   edges[NODES];
	int                edge_total = 0;
	bit                seen[NODES];
	tpdq_pkg::node_t   path_node[NODES];
	int                path_cursor[NODES];
	tpdq_pkg::weight_t path_w[NODES];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_toggle = 1'b0;
	bit  hold_seen = 1'b0;
	int  hold_left = 0;
	logic beat_taken = 1'b0;
	int  quiet_cycles = 0;
	int  errors = 0;

	tree_path_distance_query i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .node_a(node_a), .node_b(node_b), .weight(weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .found(found)
	);

	always #5 clk = ~clk;

	function automatic answer_t walk_path(tpdq_pkg::node_t start, tpdq_pkg::node_t target);
		answer_t ans;
		int sp;
		int i;
		tpdq_pkg::node_t other;
		tpdq_pkg::node_t nxt;
		tpdq_pkg::weight_t nw;
		bit moved;
		tpdq_pkg::dist_t run;
		ans.path_sum = '0;
		ans.hit = 1'b0;
		if (start == target) begin
			ans.hit = 1'b1;
			return ans;
		end
		for (i = 0; i < NODES; i++) seen[i] = 1'b0;
		run = '0;
		seen[start] = 1'b1;
		path_node[0] = start;
		path_cursor[0] = 0;
		path_w[0] = '0;
		sp = 1;
		while (sp > 0) begin
			moved = 1'b0;
			for (i = path_cursor[sp-1]; i < edge_total; i++) begin
				if (edges[i].a == path_node[sp-1]) other = edges[i].b;
				else if (edges[i].b == path_node[sp-1]) other = edges[i].a;
				else continue;
				if (!seen[other]) begin
					nxt = other;
					nw = edges[i].w;
					moved = 1'b1;
					break;
				end
			end
			if (moved) begin
				path_cursor[sp-1] = i + 1;
				run = run + tpdq_pkg::dist_t'(nw);
				if (nxt == target) begin
					ans.path_sum = run;
					ans.hit = 1'b1;
					return ans;
				end
				if (sp >= NODES) return ans;
				seen[nxt] = 1'b1;
				path_node[sp] = nxt;
				path_cursor[sp] = 0;
				path_w[sp] = nw;
				sp++;
			end else begin
				path_cursor[sp-1] = edge_total;
				run = run - tpdq_pkg::dist_t'(path_w[sp-1]);
				sp--;
			end
		end
		return ans;
	endfunction

	task automatic apply_beat(beat_t bt);
		case (bt.op)
			tpdq_pkg::OP_CLEAR: begin
				edge_total = 0;
			end
			tpdq_pkg::OP_ADD: begin
				if (edge_total < NODES - 1) begin
					edges[edge_total] = '{a: bt.a, b: bt.b, w: bt.w};
					edge_total++;
				end
			end
			tpdq_pkg::OP_QUERY: begin
				expected_answers = {expected_answers, walk_path(bt.a, bt.b)};
			end
			default: begin
			end
		endcase
	endtask

	// driver: a new beat only once the previous one has gone
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || beat_taken) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid  <= 1'b1;
				operation <= pending_beats[0].op;
				node_a    <= pending_beats[0].a;
				node_b    <= pending_beats[0].b;
				weight    <= pending_beats[0].w;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input acceptance, prediction and watchdog
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			apply_beat(pending_beats[0]);
			void'(pending_beats.pop_front());
			beat_taken <= 1'b1;
		end else begin
			beat_taken <= 1'b0;
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= 3000;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$error("result beat with nothing expected: distance %0d found %0d",
					distance, found);
				errors++;
			end else begin
				if (distance !== expected_answers[0].path_sum) begin
					$error("distance: expected %0d, got %0d",
						expected_answers[0].path_sum, distance);
					errors++;
				end
				if (found !== expected_answers[0].hit) begin
					$error("found: expected %0d, got %0d", expected_answers[0].hit, found);
					errors++;
				end
				void'(expected_answers.pop_front());
			end
		end
	end

	task automatic push(logic [tpdq_pkg::OP_W-1:0] op, int a, int b, int w);
		beat_t bt;
		bt.op = op;
		bt.a = tpdq_pkg::node_t'(a);
		bt.b = tpdq_pkg::node_t'(b);
		bt.w = tpdq_pkg::weight_t'(w);
		pending_beats = {pending_beats, bt};
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int pick_weight();
		case ($urandom_range(5))
			0: return 0;
			1: return 16'hFFFF;
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	// random tree with noise, then a batch of queries; returns beats that count
	task automatic tree_round(output int counted);
		int n;
		int labels[$];
		int lab;
		int i;
		int p;
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 28) : $urandom_range(2, 12);
		counted = 0;
		while (labels.size() < n) begin
			case ($urandom_range(9))
				0: lab = 0;
				1: lab = NODES - 1;
				default: lab = $urandom_range(NODES - 1);
			endcase
			if (!(lab inside {labels})) labels = {labels, lab};
		end
		push(tpdq_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
		counted++;
		for (i = 1; i < n; i++) begin
			p = $urandom_range(i - 1);
			// occasionally leave a node disconnected
			if ($urandom_range(14) != 0) begin
				if ($urandom_range(1)) push(tpdq_pkg::OP_ADD, labels[i], labels[p], pick_weight());
				else push(tpdq_pkg::OP_ADD, labels[p], labels[i], pick_weight());
				counted++;
			end
			if ($urandom_range(19) == 0) begin
				push(tpdq_pkg::OP_ADD, labels[i], labels[i], pick_weight());
				counted++;
			end
			if ($urandom_range(19) == 0) begin
				push(OP_UNUSED, $urandom, $urandom, $urandom);
			end
		end
		for (i = 0; i < $urandom_range(3, 7); i++) begin
			case ($urandom_range(9))
				0: push(tpdq_pkg::OP_QUERY, labels[$urandom_range(n - 1)],
					labels[$urandom_range(n - 1)], $urandom);
				1: push(tpdq_pkg::OP_QUERY, $urandom_range(NODES - 1),
					labels[$urandom_range(n - 1)], $urandom);
				default: begin
					lab = $urandom_range(n - 1);
					push(tpdq_pkg::OP_QUERY, labels[lab], labels[$urandom_range(n - 1)],
						$urandom);
				end
			endcase
			counted++;
		end
	endtask

	initial begin
		int total;
		int got;
		int phase;
		int i;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every operation, corner cases
		push(tpdq_pkg::OP_CLEAR, 0, 0, 0);
		push(tpdq_pkg::OP_ADD, 0, 1023, 16'hFFFF);
		push(tpdq_pkg::OP_ADD, 1023, 5, 0);
		push(tpdq_pkg::OP_ADD, 5, 5, 1);
		push(tpdq_pkg::OP_ADD, 0, 1023, 1);
		push(OP_UNUSED, 1023, 1023, 16'hFFFF);
		push(tpdq_pkg::OP_QUERY, 0, 5, 0);
		push(tpdq_pkg::OP_QUERY, 5, 0, 16'hFFFF);
		push(tpdq_pkg::OP_QUERY, 7, 7, 0);
		push(tpdq_pkg::OP_QUERY, 0, 7, 0);
		push(tpdq_pkg::OP_QUERY, 1023, 1023, 0);
		push(tpdq_pkg::OP_ADD, 512, 341, 16'hAAAA);
		push(tpdq_pkg::OP_ADD, 341, 682, 16'h5555);
		push(tpdq_pkg::OP_QUERY, 512, 682, 0);
		push(tpdq_pkg::OP_QUERY, 341, 0, 0);
		push(tpdq_pkg::OP_QUERY, 1023, 0, 0);
		drain();

		// long receiver hold-off while queries and loads queue up
		hold_toggle = ~hold_toggle;
		push(tpdq_pkg::OP_QUERY, 0, 5, 0);
		push(tpdq_pkg::OP_QUERY, 682, 512, 0);
		for (i = 0; i < 6; i++) push(tpdq_pkg::OP_ADD, 100 + i, 101 + i, $urandom);
		push(tpdq_pkg::OP_QUERY, 100, 106, 0);
		push(tpdq_pkg::OP_QUERY, 3, 3, 0);
		drain();

		total = 0;
		phase = 0;
		while (total < 240 || phase < 4) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (i = 0; i < 4; i++) begin
				tree_round(got);
				total += got;
			end
			// sender pauses until every answer is back
			drain();
			phase++;
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_answers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tpdq_pkg.sv
hw/rtl/tpdq_ram.sv
hw/rtl/tree_path_distance_query.sv
test/tb_tree_path_distance_query.sv
